// ===== rtl/vm_operand_stack_assert.svh =====
// Assertion macros shared by the operand stack RTL.
`ifndef VM_OPERAND_STACK_ASSERT_SVH
`define VM_OPERAND_STACK_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define VMOS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define VMOS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vmos_pkg.sv =====
// Types and constants of the operand stack.
package vmos_pkg;

    localparam int SLOT_W  = 32;
    localparam int VALUE_W = 64;
    localparam int SIZE_W  = 9;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;

    localparam logic [SIZE_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_ONE = 3'd0,
        MODE_PUSH_TWO = 3'd1,
        MODE_POP_ONE  = 3'd2,
        MODE_POP_TWO  = 3'd3,
        MODE_PEEK_ONE = 3'd4,
        MODE_PEEK_TWO = 3'd5,
        MODE_SWAP     = 3'd6
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [STAT_W-1:0]  status;
        logic [SIZE_W-1:0]  size_after;
        logic               is_empty;
    } rsp_t;

    typedef struct packed {
        logic [SIZE_W-1:0] capacity_limit;
    } cfg_t;

endpackage

// ===== rtl/vmos_chan_if.sv =====
// Valid/ready channel carrying one payload struct.
interface vmos_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/vmos_bank.sv =====
// One bank of slot storage: single write port, registered read port.
module vmos_bank #(
    parameter int ROWS  = 128,
    parameter int ROW_W = 7
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ROW_W-1:0]            wr_row,
    input  logic [vmos_pkg::SLOT_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ROW_W-1:0]            rd_row,
    output logic [vmos_pkg::SLOT_W-1:0] rd_data
);

    logic [vmos_pkg::SLOT_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_row];
        end
    end

endmodule

// ===== rtl/vmos_ctrl.sv =====
// Request sequencer: reads the top two slots, executes, writes back, reports.
module vmos_ctrl #(
    parameter int DEPTH = 256,
    parameter int ROW_W = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    vmos_chan_if.sink                         req,
    vmos_chan_if.source                       rsp,
    input  logic [vmos_pkg::SIZE_W-1:0]       cap_limit,
    output logic [1:0]                        rd_en,
    output logic [1:0][ROW_W-1:0]             rd_row,
    input  logic [1:0][vmos_pkg::SLOT_W-1:0]  rd_data,
    output logic [1:0]                        wr_en,
    output logic [1:0][ROW_W-1:0]             wr_row,
    output logic [1:0][vmos_pkg::SLOT_W-1:0]  wr_data
);

    localparam int SW = vmos_pkg::SIZE_W;
    localparam int DW = vmos_pkg::SLOT_W;
    localparam logic [SW-1:0] DEPTH_CAP = SW'((DEPTH < 511) ? DEPTH : 511);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [SW-1:0]       size_reg, size_next;
    vmos_pkg::req_t      req_reg;
    vmos_pkg::rsp_t      rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                accept;
    logic                exec;
    logic [SW-1:0]       top_idx, below_idx;
    logic [DW-1:0]       top_data, below_data;
    logic [SW-1:0]       usable;
    logic [SW:0]         size_p1, size_p2;
    logic [SW-1:0]       exec_size;
    vmos_pkg::status_t   exec_status;
    logic [vmos_pkg::VALUE_W-1:0] exec_value;
    logic                wa_en, wb_en;
    logic [SW-1:0]       a_idx, b_idx;
    logic [DW-1:0]       a_data, b_data;

    // slot index -> row within its bank (bank is the index LSB)
    function automatic logic [ROW_W-1:0] row_of(input logic [SW-1:0] idx);
        logic [ROW_W+SW-2:0] wide;
        wide = {{ROW_W{1'b0}}, idx[SW-1:1]};
        return wide[ROW_W-1:0];
    endfunction

    assign accept    = req.valid && req.ready;
    assign exec      = (state_reg == S_EXEC);
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    assign top_idx    = size_reg - SW'(1);
    assign below_idx  = size_reg - SW'(2);
    assign top_data   = rd_data[top_idx[0]];
    assign below_data = rd_data[~top_idx[0]];
    assign usable     = (cap_limit < DEPTH_CAP) ? cap_limit : DEPTH_CAP;
    assign size_p1    = {1'b0, size_reg} + (SW+1)'(1);
    assign size_p2    = {1'b0, size_reg} + (SW+1)'(2);

    // top two slots always sit in opposite banks
    always_comb
    begin
        rd_en                  = {2{accept}};
        rd_row                 = '0;
        rd_row[top_idx[0]]     = row_of(top_idx);
        rd_row[~top_idx[0]]    = row_of(below_idx);
    end

    always_comb
    begin
        exec_status = vmos_pkg::ST_OK;
        exec_value  = '0;
        exec_size   = size_reg;
        wa_en       = 1'b0;
        wb_en       = 1'b0;
        a_idx       = size_reg;
        b_idx       = size_p1[SW-1:0];
        a_data      = req_reg.push_value[DW-1:0];
        b_data      = req_reg.push_value[DW-1:0];
        unique case (req_reg.mode) inside
            vmos_pkg::MODE_PUSH_ONE:
            begin
                if (size_p1 > {1'b0, usable})
                begin
                    exec_status = vmos_pkg::ST_OVERFLOW;
                end
                else
                begin
                    wa_en     = 1'b1;
                    exec_size = size_p1[SW-1:0];
                end
            end
            vmos_pkg::MODE_PUSH_TWO:
            begin
                if (size_p2 > {1'b0, usable})
                begin
                    exec_status = vmos_pkg::ST_OVERFLOW;
                end
                else
                begin
                    wa_en     = 1'b1;
                    wb_en     = 1'b1;
                    a_data    = req_reg.push_value[2*DW-1:DW];
                    exec_size = size_p2[SW-1:0];
                end
            end
            vmos_pkg::MODE_POP_ONE, vmos_pkg::MODE_PEEK_ONE:
            begin
                if (size_reg == '0)
                begin
                    exec_status = vmos_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    exec_value = {{DW{1'b0}}, top_data};
                    if (req_reg.mode == vmos_pkg::MODE_POP_ONE)
                    begin
                        exec_size = top_idx;
                    end
                end
            end
            vmos_pkg::MODE_POP_TWO, vmos_pkg::MODE_PEEK_TWO:
            begin
                if (size_reg < SW'(2))
                begin
                    exec_status = vmos_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    exec_value = {below_data, top_data};
                    if (req_reg.mode == vmos_pkg::MODE_POP_TWO)
                    begin
                        exec_size = below_idx;
                    end
                end
            end
            vmos_pkg::MODE_SWAP:
            begin
                if (size_reg < SW'(2))
                begin
                    exec_status = vmos_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    wa_en  = 1'b1;
                    wb_en  = 1'b1;
                    a_idx  = top_idx;
                    a_data = below_data;
                    b_idx  = below_idx;
                    b_data = top_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    // a and b are adjacent slots, so they land in different banks
    always_comb
    begin
        wr_en                = '0;
        wr_row               = '0;
        wr_data              = '0;
        wr_en[a_idx[0]]      = exec && wa_en;
        wr_row[a_idx[0]]     = row_of(a_idx);
        wr_data[a_idx[0]]    = a_data;
        wr_en[~a_idx[0]]     = exec && wb_en;
        wr_row[~a_idx[0]]    = row_of(b_idx);
        wr_data[~a_idx[0]]   = b_data;
    end

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next          = S_IDLE;
                size_next           = exec_size;
                rsp_valid_next      = 1'b1;
                rsp_next.read_value = exec_value;
                rsp_next.status     = exec_status;
                rsp_next.size_after = exec_size;
                rsp_next.is_empty   = (exec_size == '0);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req.data;
        end
        rsp_reg <= rsp_next;
    end

    `include "vm_operand_stack_assert.svh"

    `VMOS_ASSERT_IMP(a_size_bound, 1'b1, size_reg <= DEPTH_CAP, "stack size beyond capacity")
    `VMOS_ASSERT_NXT(a_accept_exec, accept, state_reg == S_EXEC, "accepted request not executed")
    `VMOS_ASSERT_NXT(a_exec_rsp, exec, rsp_valid_reg, "executed request gave no response")
    `VMOS_ASSERT_NXT(a_refused_keeps, exec && (exec_status != vmos_pkg::ST_OK), $stable(size_reg), "refused request changed size")
    `VMOS_ASSERT_IMP(a_write_in_exec, wr_en != 2'b00, exec, "slot write outside execute")

endmodule

// ===== rtl/vm_operand_stack.sv =====
// Operand stack top level: capacity register, two slot banks, sequencer.
//
//   channel  dir  payload                                   handshake
//   req      in   mode, push_value                          valid/ready
//   rsp      out  read_value, status, size_after, is_empty  valid/ready
//   cfg      in   capacity_limit                            valid/ready (always ready)
//
// Each request runs as a registered read of the top two slots (even/odd banks),
// issued on accept in idle, then the execute state, which writes back; the next
// request is taken once back in idle. Result sits in an output register, so rsp
// stall only blocks req once that register is still full.
// Reset: size 0, capacity 256; slot storage is not cleared.
module vm_operand_stack #(
    parameter int DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    vmos_chan_if.sink   req,
    vmos_chan_if.source rsp,
    vmos_chan_if.sink   cfg
);

    localparam int ROWS  = (DEPTH + 1) / 2;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [vmos_pkg::SIZE_W-1:0]           cap_reg;
    logic [1:0]                            rd_en;
    logic [1:0][ROW_W-1:0]                 rd_row;
    logic [1:0][vmos_pkg::SLOT_W-1:0]      rd_data;
    logic [1:0]                            wr_en;
    logic [1:0][ROW_W-1:0]                 wr_row;
    logic [1:0][vmos_pkg::SLOT_W-1:0]      wr_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= vmos_pkg::CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.data.capacity_limit;
        end
    end

    vmos_ctrl #(
        .DEPTH (DEPTH),
        .ROW_W (ROW_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cap_limit (cap_reg),
        .rd_en     (rd_en),
        .rd_row    (rd_row),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_row    (wr_row),
        .wr_data   (wr_data)
    );

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        vmos_bank #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_bank (
            .clk     (clk),
            .wr_en   (wr_en[b]),
            .wr_row  (wr_row[b]),
            .wr_data (wr_data[b]),
            .rd_en   (rd_en[b]),
            .rd_row  (rd_row[b]),
            .rd_data (rd_data[b])
        );
    end

endmodule

// ===== tb/vmos_checker.sv =====
`timescale 1ns / 1ps
// Operand stack checker: tracks the slot contents and compares every result.
module vmos_checker #(
    parameter int DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  vmos_pkg::req_t req_data,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  vmos_pkg::rsp_t rsp_data,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  vmos_pkg::cfg_t cfg_data,
    output int             fail_count,
    output int             pending,
    output int             overflow_seen,
    output int             underflow_seen,
    output int             peak_size
);

    logic [vmos_pkg::SLOT_W-1:0] slots [DEPTH];
    int                          occupied;
    int                          cap;
    vmos_pkg::rsp_t              expected_rsp_q [$];
    int                          req_count;
    int                          rsp_count;

    // Counters move on NBA so the stimulus side reads settled values at the edge.
    assign pending = req_count - rsp_count;

    function automatic int usable_slots();
        return (cap < DEPTH) ? cap : DEPTH;
    endfunction

    function automatic vmos_pkg::rsp_t stack_apply(
        input logic [vmos_pkg::MODE_W-1:0]  m,
        input logic [vmos_pkg::VALUE_W-1:0] pv);
        vmos_pkg::rsp_t              r;
        int                          need;
        logic [vmos_pkg::SLOT_W-1:0] t;
        r        = '0;
        r.status = vmos_pkg::ST_OK;
        case (m)
            vmos_pkg::MODE_PUSH_ONE, vmos_pkg::MODE_PUSH_TWO:
            begin
                need = (m == vmos_pkg::MODE_PUSH_ONE) ? 1 : 2;
                if (occupied + need > usable_slots())
                begin
                    r.status = vmos_pkg::ST_OVERFLOW;
                end
                else if (need == 1)
                begin
                    slots[occupied] = pv[31:0];
                    occupied        = occupied + 1;
                end
                else
                begin
                    // high word goes in first, low word ends on top
                    slots[occupied]     = pv[63:32];
                    slots[occupied + 1] = pv[31:0];
                    occupied            = occupied + 2;
                end
            end
            vmos_pkg::MODE_POP_ONE, vmos_pkg::MODE_POP_TWO,
            vmos_pkg::MODE_PEEK_ONE, vmos_pkg::MODE_PEEK_TWO:
            begin
                need = (m == vmos_pkg::MODE_POP_ONE || m == vmos_pkg::MODE_PEEK_ONE) ? 1 : 2;
                if (occupied < need)
                begin
                    r.status = vmos_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    if (need == 1)
                        r.read_value = {32'h0, slots[occupied - 1]};
                    else
                        r.read_value = {slots[occupied - 2], slots[occupied - 1]};
                    if (m == vmos_pkg::MODE_POP_ONE || m == vmos_pkg::MODE_POP_TWO)
                        occupied = occupied - need;
                end
            end
            vmos_pkg::MODE_SWAP:
            begin
                if (occupied < 2)
                begin
                    r.status = vmos_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    t                   = slots[occupied - 1];
                    slots[occupied - 1] = slots[occupied - 2];
                    slots[occupied - 2] = t;
                end
            end
            default:
            begin
                // unused code: no effect, plain ok result
            end
        endcase
        r.size_after = occupied[vmos_pkg::SIZE_W-1:0];
        r.is_empty   = (occupied == 0);
        if (occupied > peak_size)
            peak_size = occupied;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vmos_pkg::rsp_t want;
        vmos_pkg::rsp_t got;
        if (!rst_n)
        begin
            occupied       = 0;
            cap            = vmos_pkg::CAP_RESET;
            fail_count     = 0;
            overflow_seen  = 0;
            underflow_seen = 0;
            peak_size      = 0;
            expected_rsp_q.delete();
            req_count     <= 0;
            rsp_count     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap = cfg_data.capacity_limit;
            if (req_valid && req_ready)
            begin
                want = stack_apply(req_data.mode, req_data.push_value);
                if (want.status == vmos_pkg::ST_OVERFLOW)
                    overflow_seen = overflow_seen + 1;
                if (want.status == vmos_pkg::ST_UNDERFLOW)
                    underflow_seen = underflow_seen + 1;
                expected_rsp_q.push_back(want);
                req_count <= req_count + 1;
            end
            if (rsp_valid && rsp_ready)
            begin
                got        = rsp_data;
                rsp_count <= rsp_count + 1;
                if (expected_rsp_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding",
                                    got.read_value, 64'h0);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.size_after !== want.size_after)
                        report_mismatch("size_after", 64'(got.size_after),
                                        64'(want.size_after));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
                end
            end
        end
    end

endmodule

// ===== tb/tb_vm_operand_stack.sv =====
`timescale 1ns / 1ps
// Operand stack testbench top: clock, reset, request and capacity stimulus, verdict.
module tb_vm_operand_stack;

    localparam int                          CYCLE_LIMIT = 200000;
    localparam logic [vmos_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_CYCLIC} ready_pat_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   overflow_seen;
    int   underflow_seen;
    int   peak_size;
    int   cycle_count;
    int   burst_left;
    int   req_sent;

    vmos_chan_if #(.payload_t(vmos_pkg::req_t)) req_if ();
    vmos_chan_if #(.payload_t(vmos_pkg::rsp_t)) rsp_if ();
    vmos_chan_if #(.payload_t(vmos_pkg::cfg_t)) cfg_if ();

    vm_operand_stack u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    vmos_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_if.valid),
        .req_ready      (req_if.ready),
        .req_data       (req_if.data),
        .rsp_valid      (rsp_if.valid),
        .rsp_ready      (rsp_if.ready),
        .rsp_data       (rsp_if.data),
        .cfg_valid      (cfg_if.valid),
        .cfg_ready      (cfg_if.ready),
        .cfg_data       (cfg_if.data),
        .fail_count     (fail_count),
        .pending        (pending),
        .overflow_seen  (overflow_seen),
        .underflow_seen (underflow_seen),
        .peak_size      (peak_size)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side stalls on patterns of its own, each held for a random stretch.
    initial
    begin
        ready_pat_t pat;
        int         pat_left;
        int         tick;
        pat      = RDY_ALWAYS;
        pat_left = 0;
        tick     = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pat_left == 0)
            begin
                pat      = ready_pat_t'($urandom_range(0, 3));
                pat_left = $urandom_range(20, 200);
            end
            pat_left = pat_left - 1;
            tick     = tick + 1;
            case (pat)
                RDY_ALWAYS: rsp_if.ready <= 1'b1;
                RDY_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default:    rsp_if.ready <= (tick % 3 != 0);
            endcase
        end
    end

    task automatic send_req(input logic [vmos_pkg::MODE_W-1:0]  m,
                            input logic [vmos_pkg::VALUE_W-1:0] v);
        req_if.valid <= 1'b1;
        req_if.data  <= vmos_pkg::req_t'{mode: m, push_value: v};
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        req_sent = req_sent + 1;
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
        end
        else
        begin
            req_if.valid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Hold requests until the stack has answered everything sent so far.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending > 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_cap(input int c);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= vmos_pkg::cfg_t'{capacity_limit: c[vmos_pkg::SIZE_W-1:0]};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [vmos_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_phase(input int cap, input int count, input int push_pct);
        int                              r;
        logic [vmos_pkg::MODE_W-1:0]     m;
        drain();
        write_cap(cap);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                m = $urandom_range(0, 1) ? vmos_pkg::MODE_PUSH_TWO : vmos_pkg::MODE_PUSH_ONE;
            else if (r >= 98)
                m = MODE_UNUSED;
            else
            begin
                case ($urandom_range(0, 4))
                    0:       m = vmos_pkg::MODE_POP_ONE;
                    1:       m = vmos_pkg::MODE_POP_TWO;
                    2:       m = vmos_pkg::MODE_PEEK_ONE;
                    3:       m = vmos_pkg::MODE_PEEK_TWO;
                    default: m = vmos_pkg::MODE_SWAP;
                endcase
            end
            send_req(m, pick_value());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        burst_left   = 0;
        req_sent     = 0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack: every read and swap refused, unused code ignored
        send_req(vmos_pkg::MODE_POP_ONE, '0);
        send_req(vmos_pkg::MODE_POP_TWO, '0);
        send_req(vmos_pkg::MODE_PEEK_ONE, '0);
        send_req(vmos_pkg::MODE_PEEK_TWO, '0);
        send_req(vmos_pkg::MODE_SWAP, '0);
        send_req(MODE_UNUSED, '1);
        // one slot held: two-slot reads and swap refused; with two held they succeed
        send_req(vmos_pkg::MODE_PUSH_ONE, '1);
        send_req(vmos_pkg::MODE_PEEK_TWO, '0);
        send_req(vmos_pkg::MODE_POP_TWO, '0);
        send_req(vmos_pkg::MODE_SWAP, '0);
        send_req(vmos_pkg::MODE_PUSH_ONE, '0);
        send_req(vmos_pkg::MODE_SWAP, '1);
        send_req(vmos_pkg::MODE_PEEK_TWO, '0);
        send_req(vmos_pkg::MODE_POP_TWO, '0);
        // two-slot words: no sign extension on the join
        send_req(vmos_pkg::MODE_PUSH_TWO, 64'hFFFF_FFFF_0000_0000);
        send_req(vmos_pkg::MODE_PUSH_TWO, 64'h8000_0001_7FFF_FFFE);
        send_req(vmos_pkg::MODE_PEEK_ONE, '0);
        send_req(vmos_pkg::MODE_POP_ONE, '0);
        send_req(MODE_UNUSED, '0);
        // full at a small capacity; two-slot push with one slot free overflows
        drain();
        write_cap(3);
        send_req(vmos_pkg::MODE_PUSH_ONE, 64'h1234_5678_9ABC_DEF0);
        send_req(vmos_pkg::MODE_POP_ONE, '0);
        send_req(vmos_pkg::MODE_PUSH_TWO, '1);
        send_req(vmos_pkg::MODE_PUSH_ONE, '1);
        // capacity lowered below the current size
        drain();
        write_cap(1);
        send_req(vmos_pkg::MODE_PUSH_ONE, '1);
        send_req(vmos_pkg::MODE_SWAP, '0);
        send_req(vmos_pkg::MODE_PEEK_TWO, '0);
        send_req(vmos_pkg::MODE_POP_TWO, '0);
        drain();
        write_cap(0);
        send_req(vmos_pkg::MODE_PUSH_TWO, '1);
        send_req(vmos_pkg::MODE_POP_ONE, '0);

        // random phases: capacity above DEPTH, full, shrunk, zero, tiny
        run_phase(511, 280, 70);
        run_phase(256, 200, 35);
        run_phase(100, 220, 15);
        run_phase(0, 150, 20);
        run_phase(2, 180, 40);
        run_phase(1, 150, 40);
        run_phase($urandom_range(3, 60), 220, 40);
        run_phase(257, 250, 60);
        run_phase($urandom_range(0, 511), 150, 35);

        drain();
        repeat (10) @(posedge clk);
        $display("Ran %0d requests over 13 capacity settings, peak stack size %0d",
                 req_sent, peak_size);
        $display("Refusals checked: %0d overflow, %0d underflow",
                 overflow_seen, underflow_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
